// ===== rtl/core/dqe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dqe_pkg;

  // Longest label kept; longer labels are truncated and flagged.
  localparam int LabelMax = 63;

  localparam int CntW = $clog2(LabelMax + 1);
  localparam int IdxW = (LabelMax > 1) ? $clog2(LabelMax) : 1;
  // Stream position: length byte, label characters and five trailer bytes.
  localparam int PosW = $clog2(LabelMax + 7);

  localparam logic [7:0] ChEnd = 8'h00;
  localparam logic [7:0] ChDot = 8'h2E;

  // Trailer byte positions after the label bytes.
  localparam logic [2:0] TailRoot    = 3'd0;
  localparam logic [2:0] TailTypeHi  = 3'd1;
  localparam logic [2:0] TailTypeLo  = 3'd2;
  localparam logic [2:0] TailClassHi = 3'd3;
  localparam logic [2:0] TailClassLo = 3'd4;
  localparam logic [PosW-1:0] TailLen = PosW'(5);

  typedef struct packed {
    logic load_char;
    logic start_flush;
    logic advance;
  } dqe_cmd_t;

  typedef struct packed {
    logic term;
    logic flushable;
    logic pos_last;
    logic out_free;
  } dqe_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/dqe_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface dqe_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  ch;
  logic [15:0] qtype;
  logic [15:0] qclass;

  modport source (output valid, output ch, output qtype, output qclass, input ready);
  modport sink   (input valid, input ch, input qtype, input qclass, output ready);
endinterface

interface dqe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_first;
  logic [7:0] byte_second;
  logic       two_bytes;
  logic       overlong;
  logic       last;

  modport source (output valid, output byte_first, output byte_second, output two_bytes,
                  output overlong, output last, input ready);
  modport sink   (input valid, input byte_first, input byte_second, input two_bytes,
                  input overlong, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dqe_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dqe_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  dqe_pkg::dqe_status_t status_i,
  output dqe_pkg::dqe_cmd_t    cmd_o
);

  localparam logic StIdle  = 1'b0;
  localparam logic StFlush = 1'b1;

  logic state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (!status_i.term) begin
            cmd_o.load_char = 1'b1;
          end else if (status_i.flushable) begin
            cmd_o.start_flush = 1'b1;
            state_d           = StFlush;
          end
        end
      end
      StFlush: begin
        cmd_o.advance = status_i.out_free;
        if (status_i.out_free && status_i.pos_last) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dqe_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dqe_dp (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  dqe_pkg::dqe_cmd_t     cmd_i,
  output dqe_pkg::dqe_status_t  status_o,
  input  wire  [7:0]            ch_i,
  input  wire  [15:0]           qtype_i,
  input  wire  [15:0]           qclass_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output logic [7:0]            byte_first_o,
  output logic [7:0]            byte_second_o,
  output logic                  two_bytes_o,
  output logic                  overlong_o,
  output logic                  last_o
);

  logic [7:0] mem_q [dqe_pkg::LabelMax];

  logic [dqe_pkg::CntW-1:0] count_q;
  logic                     too_long_q;

  // Flush context captured when the dot or terminator is taken.
  logic [dqe_pkg::CntW-1:0] len_q;
  logic [dqe_pkg::PosW-1:0] lab_bytes_q;
  logic [dqe_pkg::PosW-1:0] total_q;
  logic                     flag_q;
  logic [15:0]              qtype_q;
  logic [15:0]              qclass_q;
  logic [dqe_pkg::PosW-1:0] pos_q;
  logic [7:0]               rd_q;

  // Half of a byte pair waiting for its partner.
  logic       hv_q;
  logic [7:0] hb_q;
  logic       hf_q;

  logic [dqe_pkg::PosW-1:0] lab_bytes_d;
  logic [dqe_pkg::PosW-1:0] rd_addr;
  logic [dqe_pkg::PosW-1:0] tail_pos;
  logic [7:0]               cur_byte;
  logic                     cur_flag;
  logic                     cur_last;
  logic                     emit;
  logic                     out_free;

  assign lab_bytes_d = (count_q != '0) ? (dqe_pkg::PosW'(count_q) + dqe_pkg::PosW'(1)) : '0;
  assign out_free    = !out_valid_o || out_ready_i;

  assign status_o.term      = (ch_i == dqe_pkg::ChEnd) || (ch_i == dqe_pkg::ChDot);
  assign status_o.flushable = (count_q != '0) || (ch_i == dqe_pkg::ChEnd);
  assign status_o.pos_last  = cur_last;
  assign status_o.out_free  = out_free;

  // Next label character is fetched one step ahead; on a stall the current one is kept.
  assign rd_addr  = cmd_i.advance ? pos_q : (pos_q - dqe_pkg::PosW'(1));
  assign tail_pos = pos_q - lab_bytes_q;
  assign cur_last = (pos_q == (total_q - dqe_pkg::PosW'(1)));
  assign emit     = hv_q || cur_last;

  always_comb begin
    cur_byte = 8'h00;
    cur_flag = 1'b0;
    if (pos_q < lab_bytes_q) begin
      cur_flag = flag_q;
      cur_byte = (pos_q == '0) ? 8'(len_q) : rd_q;
    end else begin
      unique case (tail_pos[2:0])
        dqe_pkg::TailRoot:    cur_byte = 8'h00;
        dqe_pkg::TailTypeHi:  cur_byte = qtype_q[15:8];
        dqe_pkg::TailTypeLo:  cur_byte = qtype_q[7:0];
        dqe_pkg::TailClassHi: cur_byte = qclass_q[15:8];
        dqe_pkg::TailClassLo: cur_byte = qclass_q[7:0];
        default:              cur_byte = 8'h00;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_char && (count_q < dqe_pkg::CntW'(dqe_pkg::LabelMax))) begin
      mem_q[count_q[dqe_pkg::IdxW-1:0]] <= ch_i;
    end
    if (rd_addr < dqe_pkg::PosW'(dqe_pkg::LabelMax)) begin
      rd_q <= mem_q[rd_addr[dqe_pkg::IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_flush) begin
      len_q       <= count_q;
      lab_bytes_q <= lab_bytes_d;
      total_q     <= lab_bytes_d + ((ch_i == dqe_pkg::ChEnd) ? dqe_pkg::TailLen : '0);
      flag_q      <= too_long_q;
      qtype_q     <= qtype_i;
      qclass_q    <= qclass_i;
    end
    if (cmd_i.advance && !emit) begin
      hb_q <= cur_byte;
      hf_q <= cur_flag;
    end
    if (cmd_i.advance && emit) begin
      byte_first_o  <= hv_q ? hb_q : cur_byte;
      byte_second_o <= hv_q ? cur_byte : 8'h00;
      two_bytes_o   <= hv_q;
      overlong_o    <= hv_q ? (hf_q || cur_flag) : cur_flag;
      last_o        <= cur_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      too_long_q  <= 1'b0;
      pos_q       <= '0;
      hv_q        <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (cmd_i.load_char) begin
        if (count_q < dqe_pkg::CntW'(dqe_pkg::LabelMax)) begin
          count_q <= count_q + dqe_pkg::CntW'(1);
        end else begin
          too_long_q <= 1'b1;
        end
      end
      if (cmd_i.start_flush) begin
        count_q    <= '0;
        too_long_q <= 1'b0;
        pos_q      <= '0;
        hv_q       <= 1'b0;
      end
      if (cmd_i.advance) begin
        pos_q <= pos_q + dqe_pkg::PosW'(1);
        hv_q  <= !emit;
      end
      if (cmd_i.advance && emit) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  a_single_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !two_bytes_o |-> last_o)
    else $error("single-byte result that is not the last of its request");

  a_pair_closed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.advance && cur_last |=> !hv_q)
    else $error("half pair left over after the final byte");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= dqe_pkg::CntW'(dqe_pkg::LabelMax))
    else $error("label count above the label limit");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.advance && emit |-> out_free)
    else $error("result register overwritten while still held");

endmodule

`default_nettype wire

// ===== rtl/core/dns_qname_label_encoder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// DNS question name encoder. Each request carries one character of a dotted
// domain name; a zero character ends the name and also supplies qtype and qclass.
// Ordinary characters are stored in a label buffer and produce no results; the
// block takes one every cycle. A dot or the terminator flushes the buffered label
// as a length byte followed by its characters, and the terminator then adds the
// root zero byte and qtype and qclass, most significant byte first. Bytes are packed
// two to a result, only the final result of a request may carry one byte, and that
// result has last set. Labels longer than 63 characters are truncated and their
// bytes are flagged overlong. A flush streams one byte per cycle while the result
// side is not stalled, through a single buffer read port, and the input is held
// from the acceptance of the dot or terminator until the flush ends. A finished
// result sits in an output register, so the next request is taken while it waits.
module dns_qname_label_encoder_unit (
  input  wire       clk_i,
  input  wire       rst_ni,
  dqe_in_if.sink    req_i,
  dqe_out_if.source rsp_o
);

  dqe_pkg::dqe_cmd_t    cmd;
  dqe_pkg::dqe_status_t status;

  // Controller sequences acceptance and flushing of each request.
  dqe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath holds the label buffer, byte stream and result register.
  dqe_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .ch_i          (req_i.ch),
    .qtype_i       (req_i.qtype),
    .qclass_i      (req_i.qclass),
    .out_valid_o   (rsp_o.valid),
    .out_ready_i   (rsp_o.ready),
    .byte_first_o  (rsp_o.byte_first),
    .byte_second_o (rsp_o.byte_second),
    .two_bytes_o   (rsp_o.two_bytes),
    .overlong_o    (rsp_o.overlong),
    .last_o        (rsp_o.last)
  );

endmodule

`default_nettype wire

// ===== verif/dns_qname_label_encoder_unit_test.sv =====
`timescale 1ns / 1ps

// Block-level test of the DNS question name encoder.
//
// Every request carries one character of a dotted domain name. Ordinary
// characters only fill the label buffer, while a dot or the zero terminator
// flushes the buffered label as a length byte plus characters. The terminator
// also appends the root byte and qtype/qclass in network order. Output bytes
// come two to a result, and last marks the final result of a request.
//
// The bench keeps its own copy of the label buffer. When a request is
// accepted, the predictor works out the byte pairs that request must produce
// and queues them. The response monitor checks every accepted result against
// the oldest queued pair, field by field.
module dns_qname_label_encoder_unit_test;

  // One output beat: a byte pair and its flags.
  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
    logic       two;
    logic       ovl;
    logic       last;
  } qname_word_t;

  // One line of the directed table. A negative n_exp means the row is checked
  // against the predictor. Otherwise exactly n_exp typed-in beats are expected.
  typedef struct {
    logic [7:0]  ch;
    logic [15:0] qtype;
    logic [15:0] qclass;
    int          reps;
    int          n_exp;
    qname_word_t exp_words [3];
  } stim_row_t;

  // Clock, reset and the two channels.
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  dqe_in_if  req_if ();
  dqe_out_if rsp_if ();

  // Bench-side drivers. They hold known values from time zero and are
  // only ever updated with nonblocking assignments at a rising edge.
  logic        req_valid  = 1'b0;
  logic [7:0]  req_ch     = 8'h00;
  logic [15:0] req_qtype  = 16'h0000;
  logic [15:0] req_qclass = 16'h0000;
  logic        rsp_ready  = 1'b0;

  assign req_if.valid  = req_valid;
  assign req_if.ch     = req_ch;
  assign req_if.qtype  = req_qtype;
  assign req_if.qclass = req_qclass;
  assign rsp_if.ready  = rsp_ready;

  dns_qname_label_encoder_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Idling knobs. Each is a percentage, and the stimulus process changes
  // them from one phase to the next.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  int mismatch_count = 0;
  int sent_count     = 0;

  // Predictor state: the label characters held so far, how many there are,
  // and whether characters past the buffer limit were dropped.
  logic [7:0]  label_chars [dqe_pkg::LabelMax];
  int unsigned label_len = 0;
  bit          label_cut = 1'b0;

  qname_word_t predicted_words [$];   // scratch output of the predictor
  qname_word_t expected_words  [$];   // beats still owed by the block
  stim_row_t   directed_rows   [$];

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic qname_word_t mk_word(input logic [7:0] first, input logic [7:0] second,
                                          input logic two, input logic ovl, input logic last);
    qname_word_t w;
    w.first  = first;
    w.second = second;
    w.two    = two;
    w.ovl    = ovl;
    w.last   = last;
    return w;
  endfunction

  // Applies one accepted character to the predictor state and appends the
  // beats it must cause to predicted_words.
  function automatic void encode_char(input logic [7:0] ch, input logic [15:0] qt,
                                      input logic [15:0] qc);
    logic [7:0]  wire_bytes [$];
    bit          wire_flags [$];
    qname_word_t w;
    int          i;
    bit          two;

    if (ch != dqe_pkg::ChEnd && ch != dqe_pkg::ChDot) begin
      // An ordinary character is buffered, or dropped once the label is full.
      if (label_len < dqe_pkg::LabelMax) begin
        label_chars[label_len] = ch;
        label_len++;
      end else begin
        label_cut = 1'b1;
      end
      return;
    end

    // A dot or the terminator flushes a non-empty label. Every byte of a
    // truncated label carries the overlong flag.
    if (label_len > 0) begin
      wire_bytes.push_back(8'(label_len));
      wire_flags.push_back(label_cut);
      for (i = 0; i < int'(label_len); i++) begin
        wire_bytes.push_back(label_chars[i]);
        wire_flags.push_back(label_cut);
      end
    end
    label_len = 0;
    label_cut = 1'b0;

    // The terminator adds the root label and then qtype and qclass, MSB first.
    if (ch == dqe_pkg::ChEnd) begin
      wire_bytes.push_back(8'h00);
      wire_bytes.push_back(qt[15:8]);
      wire_bytes.push_back(qt[7:0]);
      wire_bytes.push_back(qc[15:8]);
      wire_bytes.push_back(qc[7:0]);
      repeat (5) wire_flags.push_back(1'b0);
    end

    // Bytes are packed in pairs. Only the final beat of a request can hold
    // a single byte, and its second byte then reads as zero.
    i = 0;
    while (i < wire_bytes.size()) begin
      two      = (i + 1) < wire_bytes.size();
      w.first  = wire_bytes[i];
      w.second = two ? wire_bytes[i+1] : 8'h00;
      w.two    = two;
      w.ovl    = wire_flags[i] || (two && wire_flags[i+1]);
      i        = i + (two ? 2 : 1);
      w.last   = i >= wire_bytes.size();
      predicted_words.push_back(w);
    end
  endfunction

  function automatic void add_row(input logic [7:0] ch, input int reps, input logic [15:0] qt,
                                  input logic [15:0] qc, input int n_exp = -1,
                                  input qname_word_t w0 = '0, input qname_word_t w1 = '0,
                                  input qname_word_t w2 = '0);
    stim_row_t r;
    r.ch           = ch;
    r.reps         = reps;
    r.qtype        = qt;
    r.qclass       = qc;
    r.n_exp        = n_exp;
    r.exp_words[0] = w0;
    r.exp_words[1] = w1;
    r.exp_words[2] = w2;
    directed_rows.push_back(r);
  endfunction

  // A predictor-checked request with random qtype and qclass. Those two
  // fields matter only when the character is the terminator.
  function automatic stim_row_t plain_row(input logic [7:0] ch);
    stim_row_t r;
    r.ch     = ch;
    r.qtype  = 16'($urandom);
    r.qclass = 16'($urandom);
    r.reps   = 1;
    r.n_exp  = -1;
    foreach (r.exp_words[i]) r.exp_words[i] = '0;
    return r;
  endfunction

  // Presents one request and waits for it to be accepted. The beats it must
  // cause are then queued. Afterward the request line may go idle for a
  // random stretch. Valid stays high when no gap follows, so back-to-back
  // requests never lower and raise it within one time step.
  task automatic send_request(input stim_row_t row);
    int i;
    req_valid  <= 1'b1;
    req_ch     <= row.ch;
    req_qtype  <= row.qtype;
    req_qclass <= row.qclass;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);

    encode_char(row.ch, row.qtype, row.qclass);
    if (row.n_exp >= 0) begin
      // Typed-in rows still move the predictor state, but their own beats
      // are the expectation.
      predicted_words.delete();
      for (i = 0; i < row.n_exp; i++) expected_words.push_back(row.exp_words[i]);
    end else begin
      while (predicted_words.size() != 0) expected_words.push_back(predicted_words.pop_front());
    end
    sent_count++;

    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Holds the request line idle until every queued beat has been returned.
  task automatic drain_results();
    req_valid <= 1'b0;
    do @(posedge clk); while (expected_words.size() != 0);
  endtask

  // The response side accepts or stalls at random.
  always @(posedge clk) begin
    rsp_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // Response monitor. Values are sampled at the rising edge, before any of
  // this edge's updates land.
  always @(posedge clk) begin : response_check
    qname_word_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected result %02h %02h", rsp_if.byte_first,
                                  rsp_if.byte_second));
      end else begin
        want = expected_words.pop_front();
        if (rsp_if.byte_first !== want.first)
          report_mismatch($sformatf("byte_first %02h, expected %02h",
                                    rsp_if.byte_first, want.first));
        if (rsp_if.byte_second !== want.second)
          report_mismatch($sformatf("byte_second %02h, expected %02h",
                                    rsp_if.byte_second, want.second));
        if (rsp_if.two_bytes !== want.two)
          report_mismatch($sformatf("two_bytes %b, expected %b", rsp_if.two_bytes, want.two));
        if (rsp_if.overlong !== want.ovl)
          report_mismatch($sformatf("overlong %b, expected %b", rsp_if.overlong, want.ovl));
        if (rsp_if.last !== want.last)
          report_mismatch($sformatf("last %b, expected %b", rsp_if.last, want.last));
      end
    end
  end

  initial begin : stimulus
    int         k;
    int         m;
    int         phase;
    int         phase_start;
    int         n_labels;
    int         name_len;
    logic [7:0] c;

    // Directed table. The first rows are fresh out of reset, so their
    // beats can be read off directly.
    // An empty name is just the root byte and the trailer, at both extremes of qtype/qclass.
    add_row(dqe_pkg::ChEnd, 1, 16'hFFFF, 16'h0000, 3,
            mk_word(8'h00, 8'hFF, 1'b1, 1'b0, 1'b0),
            mk_word(8'hFF, 8'h00, 1'b1, 1'b0, 1'b0),
            mk_word(8'h00, 8'h00, 1'b0, 1'b0, 1'b1));
    add_row(dqe_pkg::ChEnd, 1, 16'h0000, 16'hFFFF, 3,
            mk_word(8'h00, 8'h00, 1'b1, 1'b0, 1'b0),
            mk_word(8'h00, 8'hFF, 1'b1, 1'b0, 1'b0),
            mk_word(8'hFF, 8'h00, 1'b0, 1'b0, 1'b1));
    // A leading dot flushes nothing.
    add_row(dqe_pkg::ChDot, 1, 16'h0000, 16'h0000, 0);
    // A one-character label fills exactly one beat.
    add_row(8'h61, 1, 16'h0000, 16'h0000, 0);
    add_row(dqe_pkg::ChDot, 1, 16'h0000, 16'h0000, 1,
            mk_word(8'h01, 8'h61, 1'b1, 1'b0, 1'b1));
    // A repeated dot gives an empty label.
    add_row(dqe_pkg::ChDot, 1, 16'h0000, 16'h0000, 0);
    // Character extremes, and codes right next to the dot.
    add_row(8'hFF, 1, 16'h0000, 16'h0000, 0);
    add_row(8'h01, 1, 16'h0000, 16'h0000, 0);
    add_row(8'h2D, 1, 16'h0000, 16'h0000, 0);
    add_row(8'h2F, 1, 16'h0000, 16'h0000, 0);
    add_row(8'h80, 1, 16'h0000, 16'h0000, 0);
    add_row(8'h7F, 1, 16'h0000, 16'h0000, 0);
    add_row(dqe_pkg::ChEnd, 1, 16'h1234, 16'h0001);
    // A terminator right after a dot adds only the trailer.
    add_row(8'h62, 1, 16'h0000, 16'h0000, 0);
    add_row(dqe_pkg::ChDot, 1, 16'h0000, 16'h0000, 1,
            mk_word(8'h01, 8'h62, 1'b1, 1'b0, 1'b1));
    add_row(dqe_pkg::ChEnd, 1, 16'h00FF, 16'hFF00, 3,
            mk_word(8'h00, 8'h00, 1'b1, 1'b0, 1'b0),
            mk_word(8'hFF, 8'hFF, 1'b1, 1'b0, 1'b0),
            mk_word(8'h00, 8'h00, 1'b0, 1'b0, 1'b1));
    // One character past the limit, the label is truncated and flagged.
    add_row(8'h7A, dqe_pkg::LabelMax + 1, 16'h0000, 16'h0000);
    add_row(dqe_pkg::ChEnd, 1, 16'hAAAA, 16'h5555);
    // After an overlong label, the next label is clean again.
    add_row(8'h71, 2, 16'h0000, 16'h0000);
    add_row(dqe_pkg::ChEnd, 1, 16'h5555, 16'hAAAA);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      repeat (directed_rows[k].reps) send_request(directed_rows[k]);
    end
    drain_results();

    // Random part in four phases: no idling, a slow request side, a slow
    // response side, and light idling on both. Each phase ends by holding
    // the request line until every beat has been returned.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 56;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 56;
        end
        default: begin
          send_idle_pct  = 15;
          recv_stall_pct = 15;
        end
      endcase
      phase_start = sent_count;
      while (sent_count - phase_start < 6) begin
        if ($urandom_range(9) < 7) begin
          // Well-formed name: a few short labels.
          n_labels = $urandom_range(0, 3);
          for (k = 0; k < n_labels; k++) begin
            if (k > 0) send_request(plain_row(dqe_pkg::ChDot));
            name_len = $urandom_range(1, 6);
            for (m = 0; m < name_len; m++) begin
              do c = 8'($urandom); while (c == dqe_pkg::ChEnd || c == dqe_pkg::ChDot);
              send_request(plain_row(c));
            end
          end
          send_request(plain_row(dqe_pkg::ChEnd));
        end else begin
          // Noise: stray dots and terminators mixed with arbitrary bytes.
          for (k = $urandom_range(1, 4); k > 0; k--) begin
            case ($urandom_range(3))
              0:       c = dqe_pkg::ChDot;
              1:       c = dqe_pkg::ChEnd;
              default: c = 8'($urandom);
            endcase
            send_request(plain_row(c));
          end
        end
      end
      drain_results();
    end

    // A terminator-ended flush lasts at most a full label plus the
    // trailer, so this margin is enough for any stray beat to show up.
    repeat (dqe_pkg::LabelMax + 20) @(posedge clk);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Timeout guard, set well above the slowest correct run.
  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/dqe_pkg.sv
rtl/core/dqe_if.sv
rtl/core/dqe_ctrl.sv
rtl/core/dqe_dp.sv
rtl/core/dns_qname_label_encoder_unit.sv
verif/dns_qname_label_encoder_unit_test.sv
